// ----- sv/wds_pkg.sv -----
// ----------------------------------------------------------------------------
// wds_pkg: shared types and constants for the distance smoother
// register indexes, widths, controller/datapath command and status
// ----------------------------------------------------------------------------
package wds_pkg;

    localparam int DIST_W      = 12;
    localparam int CFG_DIST_W  = 11;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 7;
    localparam int CFG_W       = 11;
    localparam int IDX_W       = 3;
    localparam int WEIGHT_W    = 17;   // q1.16: 16 fraction bits with room for 1.0
    localparam int NOISE_DISTANCE_DEF = 20;
    localparam int FRAC_BITS_DEF      = 8;
    localparam int DIV_W       = 40;   // dividend width of the shared divider
    localparam int DEN_W       = 24;   // divisor width of the shared divider

    typedef enum logic [IDX_W-1:0] {
        REG_DIST_MIN = 3'd0,
        REG_DIST_MAX = 3'd1,
        REG_VOL_MIN  = 3'd2,
        REG_VOL_MAX  = 3'd3,
        REG_SIG_MIN  = 3'd4,
        REG_SIG_MAX  = 3'd5,
        REG_MIN_WGT  = 3'd6,
        REG_MAX_SMP  = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,     // latch item, bump count, set up factor numerator
        OP_FACTOR,   // start factor divide
        OP_WEIGHT,   // start weight divide
        OP_MUL_RAW,  // raw * w
        OP_MUL_OLD,  // old * (1-w), sum, update state
        OP_VOLUME,   // start volume divide
        OP_DONE      // register result
    } op_t;

    typedef struct packed {
        op_t  op;
        logic div_start;
    } wds_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } wds_sts_t;

endpackage

// ----- sv/wds_datapath.sv -----
// ----------------------------------------------------------------------------
// wds_datapath: weight, state update and volume arithmetic
// one shared radix-2 restoring divider, one state-update multiplier used twice
// ----------------------------------------------------------------------------
module wds_datapath
    import wds_pkg::*;
#(
    parameter int NOISE_DISTANCE = NOISE_DISTANCE_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wds_cmd_t               cmd,
    output wds_sts_t               sts,
    input  logic [DIST_W-1:0]      distance,
    input  logic [BYTE_W-1:0]      signal_strength,
    input  logic [CFG_DIST_W-1:0]  distance_min,
    input  logic [CFG_DIST_W-1:0]  distance_max,
    input  logic [BYTE_W-1:0]      volume_min,
    input  logic [BYTE_W-1:0]      volume_max,
    input  logic [BYTE_W-1:0]      signal_min,
    input  logic [BYTE_W-1:0]      signal_max,
    input  logic [BYTE_W-1:0]      min_weight,
    input  logic [COUNT_W-1:0]     max_samples,
    output logic [DIST_W-1:0]      smoothed_distance,
    output logic [BYTE_W-1:0]      volume
);

    localparam int SV_W  = DIST_W + FRAC_BITS;
    localparam int RAW_W = DIST_W + FRAC_BITS + 1;
    localparam int PROD_W = SV_W + WEIGHT_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SV_W-1:0]     sv_reg, sv_next;
    logic [RAW_W-1:0]    raw_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [DIST_W-1:0]   sd_reg;
    logic [BYTE_W-1:0]   vol_reg;
    logic [DIV_W-1:0]    fnum_reg;       // factor numerator
    logic [DEN_W-1:0]    fden_reg;
    logic                fone_reg;       // factor saturates at 1.0

    // shared divider
    logic [DIV_W-1:0]    dq_reg;         // dividend shifting into quotient
    logic [DEN_W:0]      drem_reg;
    logic [DEN_W-1:0]    dden_reg;
    logic [CNT_W-1:0]    dcnt_reg;
    logic                dbusy_reg, ddone_reg;
    logic [DIV_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic [DEN_W:0]      rem_sh;
    logic [DEN_W+1:0]    rem_sub;

    // signal factor setup
    logic signed [9:0]   sn, sd, sn_abs, sd_abs;
    logic [COUNT_W-1:0]  limit;
    logic                noise;
    logic [16:0]         mw_num;
    logic [16:0]         fnum_small;

    // volume setup
    logic signed [SV_W+2:0] vn, vd;
    logic [SV_W:0]          vn_c, vd_a;
    logic [BYTE_W:0]        vspan_abs;
    logic                   vspan_neg;
    logic [BYTE_W-1:0]      vbase;
    logic [SV_W+BYTE_W+1:0] vnum_pos, vsub;

    logic [WEIGHT_W-1:0] one_minus_w;
    logic [SV_W-1:0]     mul_a;
    logic [WEIGHT_W-1:0] mul_b;
    logic [PROD_W-1:0]   prod;

    always_comb
    begin
        limit = (max_samples == '0) ? COUNT_W'(1) : max_samples;
        noise = (distance < DIST_W'(NOISE_DISTANCE));
        sn = $signed({2'b00, signal_strength}) - $signed({2'b00, signal_min});
        sd = $signed({2'b00, signal_max}) - $signed({2'b00, signal_min});
        if (sd < 0)
        begin
            sn_abs = -sn;
            sd_abs = -sd;
        end
        else
        begin
            sn_abs = sn;
            sd_abs = sd;
        end
        mw_num = 17'(min_weight) * 17'(sd_abs[8:0])
               + 17'(sn_abs[8:0]) * 17'(8'd255 - min_weight);
        fnum_small = 17'(min_weight);
        count_next = (count_reg < limit) ? count_reg + 1'b1 : count_reg;
    end

    // volume ratio operands
    always_comb
    begin
        vn = $signed({3'b000, sv_reg}) - $signed((SV_W+3)'({distance_min, FRAC_BITS'(0)}));
        vd = $signed((SV_W+3)'({distance_max, FRAC_BITS'(0)}))
           - $signed((SV_W+3)'({distance_min, FRAC_BITS'(0)}));
        if (vd < 0)
        begin
            vn = -vn;
            vd = -vd;
        end
        if (vn < 0)
            vn = '0;
        if (vn > vd)
            vn = vd;
        vn_c = vn[SV_W:0];
        vd_a = vd[SV_W:0];
        vspan_neg = (volume_max < volume_min);
        vspan_abs = vspan_neg ? (BYTE_W+1)'(volume_min - volume_max)
                              : (BYTE_W+1)'(volume_max - volume_min);
        vbase = 8'd255 - volume_min;
        vsub  = (SV_W+BYTE_W+2)'(vn_c) * (SV_W+BYTE_W+2)'(vspan_abs);
        vnum_pos = (SV_W+BYTE_W+2)'(vd_a) * (SV_W+BYTE_W+2)'(vbase);
        if (vspan_neg)
            vnum_pos = vnum_pos + vsub;
        else if (vnum_pos > vsub)
            vnum_pos = vnum_pos - vsub;
        else
            vnum_pos = '0;
    end

    always_comb
    begin
        div_num = '0;
        div_den = '0;
        unique case (cmd.op)
            OP_FACTOR:
            begin
                div_num = fnum_reg;
                div_den = fden_reg;
            end
            OP_WEIGHT:
            begin
                div_num = DIV_W'(fone_reg ? WEIGHT_W'(17'h10000) : dq_reg[WEIGHT_W-1:0]);
                div_den = DEN_W'(count_reg);
            end
            OP_VOLUME:
            begin
                div_num = DIV_W'(vnum_pos);
                div_den = DEN_W'(vd_a);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    assign rem_sh  = {drem_reg[DEN_W-1:0], dq_reg[DIV_W-1]};
    assign rem_sub = {1'b0, rem_sh} - {2'b00, dden_reg};

    assign one_minus_w = WEIGHT_W'(17'h10000) - w_reg;
    assign mul_a = (cmd.op == OP_MUL_RAW) ? raw_reg[SV_W-1:0] : sv_reg;
    assign mul_b = (cmd.op == OP_MUL_RAW) ? dq_reg[WEIGHT_W-1:0] : one_minus_w;
    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sv_reg    <= '0;
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dcnt_reg  <= '0;
            dq_reg    <= '0;
            drem_reg  <= '0;
            dden_reg  <= '0;
        end
        else
        begin
            ddone_reg <= 1'b0;
            if (cmd.div_start)
            begin
                dq_reg    <= div_num;
                dden_reg  <= div_den;
                drem_reg  <= '0;
                dcnt_reg  <= CNT_W'(DIV_W);
                dbusy_reg <= 1'b1;
            end
            else if (dbusy_reg)
            begin
                if (!rem_sub[DEN_W+1])
                begin
                    drem_reg <= rem_sub[DEN_W:0];
                    dq_reg   <= {dq_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= rem_sh;
                    dq_reg   <= {dq_reg[DIV_W-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == CNT_W'(1))
                begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
            case (cmd.op)
                OP_LOAD:   count_reg <= count_next;
                OP_MUL_OLD: sv_reg   <= sv_next;
                default:   ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                fone_reg <= 1'b0;
                if (noise)
                begin
                    raw_reg  <= RAW_W'({distance_max, 1'b0, FRAC_BITS'(0)});
                    fnum_reg <= DIV_W'({8'd255 - signal_min, 16'h0000});
                    fden_reg <= DEN_W'(255);
                end
                else
                begin
                    raw_reg <= RAW_W'({distance, FRAC_BITS'(0)});
                    if (sd == 0 || sn_abs <= 0)
                    begin
                        fnum_reg <= DIV_W'({fnum_small, 16'h0000});
                        fden_reg <= DEN_W'(255);
                    end
                    else if (sn_abs >= sd_abs)
                    begin
                        fone_reg <= 1'b1;
                        fnum_reg <= '0;
                        fden_reg <= DEN_W'(1);
                    end
                    else
                    begin
                        fnum_reg <= DIV_W'({mw_num, 16'h0000});
                        fden_reg <= DEN_W'(17'(sd_abs[8:0]) * 17'd255);
                    end
                end
            end
            OP_MUL_RAW:
            begin
                w_reg   <= dq_reg[WEIGHT_W-1:0];
                acc_reg <= prod;
            end
            OP_DONE:
            begin
                sd_reg  <= sv_reg[SV_W-1:FRAC_BITS];
                // equal distance ends give the lower map end
                vol_reg <= (distance_min == distance_max) ? 8'd255 - volume_min
                                                          : dq_reg[BYTE_W-1:0];
            end
            default: ;
        endcase
    end

    // weight taken from quotient once for the raw product
    logic [PROD_W:0] sum;
    assign sum = {1'b0, acc_reg} + {1'b0, prod};
    assign sv_next = sum[SV_W+16-1:16];

    assign sts.div_busy = dbusy_reg;
    assign sts.div_done = ddone_reg;
    assign smoothed_distance = sd_reg;
    assign volume = vol_reg;

endmodule

// ----- sv/wds_ctrl.sv -----
// ----------------------------------------------------------------------------
// wds_ctrl: sequencer for one item
// load, factor divide, weight divide, two multiplies, volume divide
// ----------------------------------------------------------------------------
module wds_ctrl
    import wds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  wds_sts_t sts,
    output wds_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_FDIV, S_FWAIT, S_WDIV, S_WWAIT,
        S_MRAW, S_MOLD, S_VDIV, S_VWAIT, S_DONE, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_NONE;
        cmd.div_start  = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_LOAD;
            S_LOAD:
            begin
                cmd.op = OP_LOAD;
                state_next = S_FDIV;
            end
            S_FDIV:
            begin
                cmd.op = OP_FACTOR;
                cmd.div_start = 1'b1;
                state_next = S_FWAIT;
            end
            S_FWAIT: if (sts.div_done) state_next = S_WDIV;
            S_WDIV:
            begin
                cmd.op = OP_WEIGHT;
                cmd.div_start = 1'b1;
                state_next = S_WWAIT;
            end
            S_WWAIT: if (sts.div_done) state_next = S_MRAW;
            S_MRAW:
            begin
                cmd.op = OP_MUL_RAW;
                state_next = S_MOLD;
            end
            S_MOLD:
            begin
                cmd.op = OP_MUL_OLD;
                state_next = S_VDIV;
            end
            S_VDIV:
            begin
                cmd.op = OP_VOLUME;
                cmd.div_start = 1'b1;
                state_next = S_VWAIT;
            end
            S_VWAIT: if (sts.div_done) state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op = OP_DONE;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- sv/weighted_distance_smoother.sv -----
// ----------------------------------------------------------------------------
// weighted_distance_smoother: signal-weighted moving average of lidar distance
// An item passes through acceptance, setup (load), three passes of a
// shared one-bit-per-cycle 40-step divider (factor, weight, volume), two
// multiplies and the result register; one item is in work at a time, and the
// finished result waits in an output register while the next item is taken.
// ----------------------------------------------------------------------------
module weighted_distance_smoother
    import wds_pkg::*;
#(
    parameter int NOISE_DISTANCE = NOISE_DISTANCE_DEF,
    parameter int FRAC_BITS      = FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [DIST_W-1:0]  distance,
    input  logic [BYTE_W-1:0]  signal_strength,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DIST_W-1:0]  smoothed_distance,
    output logic [BYTE_W-1:0]  volume
);

    logic [CFG_DIST_W-1:0] dmin_reg, dmax_reg;
    logic [BYTE_W-1:0]     vmin_reg, vmax_reg, smin_reg, smax_reg, mw_reg;
    logic [COUNT_W-1:0]    ms_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [BYTE_W-1:0]     sig_reg;
    wds_cmd_t cmd;
    wds_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dmin_reg <= CFG_DIST_W'(40);
            dmax_reg <= CFG_DIST_W'(600);
            vmin_reg <= 8'd0;
            vmax_reg <= 8'd255;
            smin_reg <= 8'd20;
            smax_reg <= 8'd80;
            mw_reg   <= 8'd13;
            ms_reg   <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_DIST_MIN: dmin_reg <= cfg_data;
                REG_DIST_MAX: dmax_reg <= cfg_data;
                REG_VOL_MIN:  vmin_reg <= cfg_data[BYTE_W-1:0];
                REG_VOL_MAX:  vmax_reg <= cfg_data[BYTE_W-1:0];
                REG_SIG_MIN:  smin_reg <= cfg_data[BYTE_W-1:0];
                REG_SIG_MAX:  smax_reg <= cfg_data[BYTE_W-1:0];
                REG_MIN_WGT:  mw_reg   <= cfg_data[BYTE_W-1:0];
                REG_MAX_SMP:  ms_reg   <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // item held for the length of the computation
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dist_reg <= distance;
            sig_reg  <= signal_strength;
        end
    end

    wds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    wds_datapath #(
        .NOISE_DISTANCE (NOISE_DISTANCE),
        .FRAC_BITS      (FRAC_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .distance          (dist_reg),
        .signal_strength   (sig_reg),
        .distance_min      (dmin_reg),
        .distance_max      (dmax_reg),
        .volume_min        (vmin_reg),
        .volume_max        (vmax_reg),
        .signal_min        (smin_reg),
        .signal_max        (smax_reg),
        .min_weight        (mw_reg),
        .max_samples       (ms_reg),
        .smoothed_distance (smoothed_distance),
        .volume            (volume)
    );

endmodule

// ----- sv/wds_checker.sv -----
// ----------------------------------------------------------------------------
// wds_checker: port-level checks for the distance smoother
// one item in work at a time, no immediate result, handshake stability
// ----------------------------------------------------------------------------
module wds_checker
    import wds_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DIST_W-1:0] smoothed_distance,
    input logic [BYTE_W-1:0] volume
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(smoothed_distance) && $stable(volume))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken during computation");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared without computation");

endmodule

bind weighted_distance_smoother wds_checker u_wds_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .smoothed_distance (smoothed_distance),
    .volume            (volume)
);

// ----- bench/weighted_distance_smoother_checker.sv -----
// ----------------------------------------------------------------------------
// weighted_distance_smoother_checker: result predictor and comparator
// Watches the config port and both item channels, keeps its own copy of the
// smoothing state, and checks every result against the oldest prediction.
// ----------------------------------------------------------------------------
module weighted_distance_smoother_checker
    import wds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [DIST_W-1:0]  distance,
    input  logic [BYTE_W-1:0]  signal_strength,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [DIST_W-1:0]  smoothed_distance,
    input  logic [BYTE_W-1:0]  volume,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count
);

    localparam longint UNITY = 65536;

    typedef struct packed {
        logic [DIST_W-1:0] dist_val;
        logic [BYTE_W-1:0] vol;
    } smooth_result_t;

    smooth_result_t expected_results[$];

    longint d_lo, d_hi, v_lo, v_hi, s_lo, s_hi, w_floor, n_limit;
    longint count_now;
    longint avg_state;

    function automatic longint strength_weight(longint s);
        longint n, d;
        n = s - s_lo;
        d = s_hi - s_lo;
        if (d == 0)
            return (w_floor * UNITY) / 255;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        if (n <= 0)
            return (w_floor * UNITY) / 255;
        if (n >= d)
            return UNITY;
        return ((w_floor * d + n * (255 - w_floor)) * UNITY) / (255 * d);
    endfunction

    function automatic longint loudness(longint x);
        longint n, d, num;
        if (d_lo == d_hi)
            return 255 - v_lo;
        n = x - (d_lo << FRAC_BITS_DEF);
        d = (d_hi - d_lo) <<< FRAC_BITS_DEF;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        if (n < 0) n = 0;
        if (n > d) n = d;
        num = (255 - v_lo) * d - n * (v_hi - v_lo);
        if (num < 0) num = 0;
        return (num / d) & 255;
    endfunction

    task automatic smooth_sample(input longint dist_in, input longint sig);
        longint lim, f, w, raw;
        smooth_result_t r;
        lim = (n_limit == 0) ? 1 : n_limit;
        if (count_now < lim)
            count_now = (count_now + 1) & 127;
        if (dist_in < NOISE_DISTANCE_DEF)
        begin
            raw = 2 * d_hi;
            f = ((255 - s_lo) * UNITY) / 255;
        end
        else
        begin
            raw = dist_in;
            f = strength_weight(sig);
        end
        w = (count_now != 0) ? f / count_now : f;
        avg_state = (((raw << FRAC_BITS_DEF) * w + avg_state * (UNITY - w)) >> 16)
                    & ((64'd1 << (12 + FRAC_BITS_DEF)) - 1);
        r.dist_val = DIST_W'(avg_state >> FRAC_BITS_DEF);
        r.vol      = BYTE_W'(loudness(avg_state));
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        smooth_result_t e;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            d_lo = 40; d_hi = 600; v_lo = 0; v_hi = 255;
            s_lo = 20; s_hi = 80; w_floor = 13; n_limit = 1;
            count_now = 0;
            avg_state = 0;
            expected_results.delete();
            fail_count <= 0;
            pending <= 0;
            result_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_DIST_MIN: d_lo = longint'(cfg_data[CFG_DIST_W-1:0]);
                    REG_DIST_MAX: d_hi = longint'(cfg_data[CFG_DIST_W-1:0]);
                    REG_VOL_MIN:  v_lo = longint'(cfg_data[BYTE_W-1:0]);
                    REG_VOL_MAX:  v_hi = longint'(cfg_data[BYTE_W-1:0]);
                    REG_SIG_MIN:  s_lo = longint'(cfg_data[BYTE_W-1:0]);
                    REG_SIG_MAX:  s_hi = longint'(cfg_data[BYTE_W-1:0]);
                    REG_MIN_WGT:  w_floor = longint'(cfg_data[BYTE_W-1:0]);
                    REG_MAX_SMP:  n_limit = longint'(cfg_data[COUNT_W-1:0]);
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: dist %0d vol %0d", smoothed_distance, volume);
                    errs++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (smoothed_distance !== e.dist_val)
                    begin
                        $error("smoothed_distance expected %0d got %0d",
                               e.dist_val, smoothed_distance);
                        errs++;
                    end
                    if (volume !== e.vol)
                    begin
                        $error("volume expected %0d got %0d", e.vol, volume);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
            if (in_valid && in_ready)
                smooth_sample(longint'(distance), longint'(signal_strength));
            pending <= expected_results.size();
        end
    end

endmodule

// ----- bench/weighted_distance_smoother_test.sv -----
// ----------------------------------------------------------------------------
// weighted_distance_smoother_test: stimulus and verdict for the smoother
// Runs directed and random lidar items through several register settings
// with random gaps on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module weighted_distance_smoother_test;
    import wds_pkg::*;

    localparam int WATCHDOG = 20000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [DIST_W-1:0] distance;
    logic [BYTE_W-1:0] signal_strength;
    logic              out_valid;
    logic              out_ready;
    logic [DIST_W-1:0] smoothed_distance;
    logic [BYTE_W-1:0] volume;
    int                fail_count;
    int                pending;
    int                result_count;
    int                idle_cycles;
    int                items_sent;
    bit                long_hold_req;
    bit                long_hold_done;

    weighted_distance_smoother dut (.*);

    weighted_distance_smoother_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 200);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (long_hold_req && !long_hold_done)
            begin
                out_ready <= 1'b0;
                repeat (2000) @(posedge clk);
                long_hold_done = 1'b1;
            end
            out_ready <= 1'b1;
            @(posedge clk);
            n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_item(input logic [DIST_W-1:0] d, input logic [BYTE_W-1:0] s);
        in_valid <= 1'b1;
        distance <= d;
        signal_strength <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_gapped(input logic [DIST_W-1:0] d, input logic [BYTE_W-1:0] s);
        int g;
        send_item(d, s);
        g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int unsigned v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_setting(input int kind);
        int unsigned lo, hi;
        case (kind)
            0:
            begin
                lo = 0; hi = 0;
            end
            1:
            begin
                lo = 1500; hi = 1500;
            end
            2:
            begin
                lo = 1500; hi = 0;
            end
            default:
            begin
                lo = $urandom_range(0, 1500); hi = $urandom_range(0, 1500);
            end
        endcase
        write_reg(REG_DIST_MIN, lo);
        write_reg(REG_DIST_MAX, hi);
        write_reg(REG_VOL_MIN, kind == 1 ? 255 : $urandom_range(0, 255));
        write_reg(REG_VOL_MAX, kind == 0 ? 0 : $urandom_range(0, 255));
        lo = $urandom_range(0, 255);
        hi = (kind == 2) ? lo : $urandom_range(0, 255);
        write_reg(REG_SIG_MIN, kind == 1 ? 255 : lo);
        write_reg(REG_SIG_MAX, kind == 0 ? 255 : hi);
        write_reg(REG_MIN_WGT, kind == 1 ? 255 : $urandom_range(0, 255));
        write_reg(REG_MAX_SMP, kind == 0 ? 0 : (kind == 1 ? 100 : $urandom_range(0, 100)));
    endtask

    initial
    begin
        int ph;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        distance = '0;
        signal_strength = '0;
        items_sent = 0;
        long_hold_req = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, noise substitution, signal clamps
        send_item(12'd0, 8'd0);
        send_item(12'd4095, 8'd255);
        send_item(12'd19, 8'd50);
        send_item(12'd20, 8'd20);
        send_item(12'd600, 8'd80);
        send_item(12'd40, 8'd10);
        drain();
        write_reg(REG_MAX_SMP, 8);
        send_item(12'd100, 8'd50);
        send_item(12'd3000, 8'd100);
        send_item(12'd0, 8'd255);
        send_item(12'd2730, 8'd170);
        send_item(12'd1365, 8'd85);
        drain();
        // lowered maximum below the current count, inverted signal and distance ranges
        write_reg(REG_MAX_SMP, 2);
        write_reg(REG_SIG_MIN, 90);
        write_reg(REG_SIG_MAX, 30);
        write_reg(REG_DIST_MIN, 700);
        write_reg(REG_DIST_MAX, 100);
        send_item(12'd500, 8'd60);
        send_item(12'd50, 8'd95);
        send_item(12'd2048, 8'd10);
        send_item(12'd5, 8'd0);
        drain();

        // receiver holds off while the sender keeps offering
        long_hold_req = 1'b1;
        repeat (20) send_item(DIST_W'($urandom_range(0, 4095)), BYTE_W'($urandom_range(0, 255)));
        drain();

        for (ph = 0; ph < 9; ph++)
        begin
            random_setting(ph);
            repeat (200)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_gapped(DIST_W'($urandom_range(0, 25)),
                                BYTE_W'($urandom_range(0, 255)));
                else
                    send_gapped(DIST_W'($urandom_range(0, 4095)),
                                BYTE_W'($urandom_range(0, 255)));
            end
            drain();
        end

        $display("sent %0d items, %0d results checked across 9 random register settings",
                 items_sent, result_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
